// File: rtl/core/qle_pkg.sv
// Package for the quicksort engine: sizes, index widths, the command and
// status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package qle_pkg;

  // Storage sizes and field widths.
  localparam int unsigned ELEMENTS    = 64;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned TALLY_W     = 12;

  localparam logic [CNT_W-1:0]   STORE_FULL = CNT_W'(ELEMENTS);
  localparam logic [CNT_W-1:0]   STACK_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [TALLY_W-1:0] TALLY_MAX  = '1;

  // Element store read address source.
  typedef enum logic [1:0] {
    RD_HI,
    RD_J,
    RD_ST,
    RD_K
  } rd_sel_e;

  // Element store write source.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_KEY,
    WR_Y,
    WR_ST
  } wr_sel_e;

  // Range pushed onto the stack.
  typedef enum logic [1:0] {
    PUSH_INIT,
    PUSH_LEFT,
    PUSH_RIGHT
  } push_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_key;
    logic      push_en;
    push_sel_e push_sel;
    logic      pop;
    logic      range_load;
    logic      rd_en;
    rd_sel_e   rd_sel;
    wr_sel_e   wr_sel;
    logic      pivot_load;
    logic      adv_j;
    logic      adv_st;
    logic      bump_cmp;
    logic      bump_swap;
    logic      swap_loop;
    logic      swap_pivot;
    logic      emit_init;
    logic      out_load;
    logic      out_clear;
    logic      k_inc;
    logic      run_clear;
  } qle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_lt2;
    logic sp_zero;
    logic lo_ge_hi;
    logic j_eq_hi;
    logic key_less;
    logic st_eq_j;
    logic push_left_ok;
    logic push_right_ok;
    logic last_k;
  } qle_status_t;

endpackage

// File: rtl/core/qle_dp.sv
// Datapath of the quicksort engine: element store, range stack, partition
// indices, tallies and the output register. Depends on qle_pkg.
`timescale 1ns / 1ps

module qle_dp import qle_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qle_cmd_t             cmd_i,
  output qle_status_t          status_o,
  input  logic [KEY_WIDTH-1:0] key_value_i,
  output logic                 out_valid_o,
  output logic [KEY_WIDTH-1:0] sorted_value_o,
  output logic [IDX_W-1:0]     position_o,
  output logic                 end_of_run_o,
  output logic [TALLY_W-1:0]   compare_count_o,
  output logic [TALLY_W-1:0]   swap_count_o,
  output logic                 overflow_flag_o
);

  // Memories; both have registered read data.
  logic [KEY_WIDTH-1:0] elem_mem [ELEMENTS];
  logic [2*IDX_W-1:0]   stack_mem [STACK_DEPTH];
  logic [KEY_WIDTH-1:0] elem_rdata_q;
  logic [2*IDX_W-1:0]   stack_rdata_q;

  // Control state.
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   sp_q, sp_d;
  logic [TALLY_W-1:0] cmp_q, cmp_d;
  logic [TALLY_W-1:0] swp_q, swp_d;
  logic               drop_q, drop_d;
  logic               out_valid_q, out_valid_d;

  // Payload registers.
  logic [IDX_W-1:0]     lo_q, hi_q, j_q, st_q, y_q, k_q;
  logic [KEY_WIDTH-1:0] pivot_q, v_q;
  logic [KEY_WIDTH-1:0] out_value_q;
  logic [IDX_W-1:0]     out_pos_q;
  logic                 out_end_q;
  logic [TALLY_W-1:0]   out_cmp_q, out_swp_q;
  logic                 out_ovf_q;

  logic [IDX_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   sp_m1;
  logic [CNT_W-1:0]   count_m1;
  logic [2*IDX_W-1:0] push_data;
  logic               store_full;

  assign store_full = (count_q == STORE_FULL);
  assign sp_m1      = sp_q - CNT_W'(1);
  assign count_m1   = count_q - CNT_W'(1);

  // Read address selection.
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_HI:   rd_addr = hi_q;
      RD_J:    rd_addr = j_q;
      RD_ST:   rd_addr = st_q;
      RD_K:    rd_addr = k_q;
      default: rd_addr = k_q;
    endcase
  end

  // Range pushed onto the stack, packed as {lo, hi}.
  always_comb begin
    unique case (cmd_i.push_sel)
      PUSH_INIT:  push_data = {IDX_W'(0), count_m1[IDX_W-1:0]};
      PUSH_LEFT:  push_data = {lo_q, st_q - IDX_W'(1)};
      PUSH_RIGHT: push_data = {st_q + IDX_W'(1), hi_q};
      default:    push_data = {lo_q, hi_q};
    endcase
  end

  // Element store.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.wr_sel)
      WR_KEY: begin
        if (!store_full) begin
          elem_mem[count_q[IDX_W-1:0]] <= key_value_i;
        end
      end
      WR_Y:    elem_mem[y_q]  <= elem_rdata_q;
      WR_ST:   elem_mem[st_q] <= v_q;
      default: ;
    endcase
    if (cmd_i.rd_en) begin
      elem_rdata_q <= elem_mem[rd_addr];
    end
  end

  // Range stack.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_en && (sp_q < STACK_FULL)) begin
      stack_mem[sp_q[IDX_W-1:0]] <= push_data;
    end
    if (cmd_i.pop) begin
      stack_rdata_q <= stack_mem[sp_m1[IDX_W-1:0]];
    end
  end

  // Next values of counters, tallies and flags.
  always_comb begin
    count_d     = count_q;
    sp_d        = sp_q;
    cmp_d       = cmp_q;
    swp_d       = swp_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    if (cmd_i.load_key) begin
      if (store_full) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
    if (cmd_i.push_en && (sp_q < STACK_FULL)) begin
      sp_d = sp_q + CNT_W'(1);
    end
    if (cmd_i.pop) begin
      sp_d = sp_m1;
    end
    if (cmd_i.bump_cmp && (cmp_q != TALLY_MAX)) begin
      cmp_d = cmp_q + TALLY_W'(1);
    end
    if (cmd_i.bump_swap && (swp_q != TALLY_MAX)) begin
      swp_d = swp_q + TALLY_W'(1);
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
    if (cmd_i.out_clear) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.run_clear) begin
      count_d = '0;
      sp_d    = '0;
      cmp_d   = '0;
      swp_d   = '0;
      drop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sp_q        <= '0;
      cmp_q       <= '0;
      swp_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      sp_q        <= sp_d;
      cmp_q       <= cmp_d;
      swp_q       <= swp_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Partition indices, pivot and swap operands.
  always_ff @(posedge clk_i) begin
    if (cmd_i.range_load) begin
      lo_q <= stack_rdata_q[2*IDX_W-1:IDX_W];
      hi_q <= stack_rdata_q[IDX_W-1:0];
    end
    if (cmd_i.pivot_load) begin
      pivot_q <= elem_rdata_q;
      j_q     <= lo_q;
      st_q    <= lo_q;
    end
    if (cmd_i.adv_j) begin
      j_q <= j_q + IDX_W'(1);
    end
    if (cmd_i.adv_st) begin
      st_q <= st_q + IDX_W'(1);
    end
    if (cmd_i.swap_loop) begin
      v_q <= elem_rdata_q;
      y_q <= j_q;
    end
    if (cmd_i.swap_pivot) begin
      v_q <= pivot_q;
      y_q <= hi_q;
    end
    if (cmd_i.emit_init) begin
      k_q <= '0;
    end
    if (cmd_i.k_inc) begin
      k_q <= k_q + IDX_W'(1);
    end
  end

  // Output register for one result beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= elem_rdata_q;
      out_pos_q   <= k_q;
      out_end_q   <= status_o.last_k;
      out_cmp_q   <= cmp_q;
      out_swp_q   <= swp_q;
      out_ovf_q   <= drop_q;
    end
  end

  // Status toward the controller.
  assign status_o.count_lt2     = (count_q < CNT_W'(2));
  assign status_o.sp_zero       = (sp_q == '0);
  assign status_o.lo_ge_hi      = (lo_q >= hi_q);
  assign status_o.j_eq_hi       = (j_q == hi_q);
  assign status_o.key_less      = ($signed(elem_rdata_q) < $signed(pivot_q));
  assign status_o.st_eq_j       = (st_q == j_q);
  assign status_o.push_left_ok  = ({1'b0, st_q} >= ({1'b0, lo_q} + CNT_W'(2)));
  assign status_o.push_right_ok = (({1'b0, st_q} + CNT_W'(2)) <= {1'b0, hi_q});
  assign status_o.last_k        = ({1'b0, k_q} == count_m1);

  assign out_valid_o     = out_valid_q;
  assign sorted_value_o  = out_value_q;
  assign position_o      = out_pos_q;
  assign end_of_run_o    = out_end_q;
  assign compare_count_o = out_cmp_q;
  assign swap_count_o    = out_swp_q;
  assign overflow_flag_o = out_ovf_q;

endmodule

// File: rtl/core/qle_ctrl.sv
// Controller of the quicksort engine: sequences loading, partitioning,
// stack handling and result emission. Depends on qle_pkg.
`timescale 1ns / 1ps

module qle_ctrl import qle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        last_key_i,
  input  logic        out_ready_i,
  input  qle_status_t status_i,
  output qle_cmd_t    cmd_o
);

  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_POP     = 4'd2;
  localparam logic [3:0] S_RANGE   = 4'd3;
  localparam logic [3:0] S_CHECK   = 4'd4;
  localparam logic [3:0] S_PIV     = 4'd5;
  localparam logic [3:0] S_RDJ     = 4'd6;
  localparam logic [3:0] S_CMP     = 4'd7;
  localparam logic [3:0] S_SW0     = 4'd8;
  localparam logic [3:0] S_SW1     = 4'd9;
  localparam logic [3:0] S_SW2     = 4'd10;
  localparam logic [3:0] S_PUSHL   = 4'd11;
  localparam logic [3:0] S_PUSHR   = 4'd12;
  localparam logic [3:0] S_EMIT_RD = 4'd13;
  localparam logic [3:0] S_EMIT_LD = 4'd14;
  localparam logic [3:0] S_EMIT_HD = 4'd15;

  logic [3:0] state_q, state_d;
  logic       pivot_swap_q, pivot_swap_d;

  assign in_ready_o = (state_q == S_LOAD);

  // Next state and command decode.
  always_comb begin
    state_d      = state_q;
    pivot_swap_d = pivot_swap_q;
    cmd_o        = '0;
    cmd_o.rd_sel   = RD_K;
    cmd_o.wr_sel   = WR_NONE;
    cmd_o.push_sel = PUSH_INIT;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load_key = 1'b1;
          cmd_o.wr_sel   = WR_KEY;
          if (last_key_i) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (status_i.count_lt2) begin
          cmd_o.emit_init = 1'b1;
          state_d         = S_EMIT_RD;
        end else begin
          cmd_o.push_en  = 1'b1;
          cmd_o.push_sel = PUSH_INIT;
          state_d        = S_POP;
        end
      end
      S_POP: begin
        if (status_i.sp_zero) begin
          cmd_o.emit_init = 1'b1;
          state_d         = S_EMIT_RD;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_RANGE;
        end
      end
      S_RANGE: begin
        cmd_o.range_load = 1'b1;
        state_d          = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.lo_ge_hi) begin
          state_d = S_POP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_HI;
          state_d      = S_PIV;
        end
      end
      S_PIV: begin
        cmd_o.pivot_load = 1'b1;
        state_d          = S_RDJ;
      end
      S_RDJ: begin
        if (status_i.j_eq_hi) begin
          // Scan done: swap the pivot into its slot.
          cmd_o.swap_pivot = 1'b1;
          pivot_swap_d     = 1'b1;
          state_d          = S_SW0;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_J;
          state_d      = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.bump_cmp = 1'b1;
        if (status_i.key_less) begin
          if (status_i.st_eq_j) begin
            cmd_o.adv_j  = 1'b1;
            cmd_o.adv_st = 1'b1;
            state_d      = S_RDJ;
          end else begin
            cmd_o.swap_loop = 1'b1;
            pivot_swap_d    = 1'b0;
            state_d         = S_SW0;
          end
        end else begin
          cmd_o.adv_j = 1'b1;
          state_d     = S_RDJ;
        end
      end
      S_SW0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_ST;
        state_d      = S_SW1;
      end
      S_SW1: begin
        cmd_o.wr_sel = WR_Y;
        state_d      = S_SW2;
      end
      S_SW2: begin
        cmd_o.wr_sel    = WR_ST;
        cmd_o.bump_swap = 1'b1;
        if (pivot_swap_q) begin
          state_d = S_PUSHL;
        end else begin
          cmd_o.adv_j  = 1'b1;
          cmd_o.adv_st = 1'b1;
          state_d      = S_RDJ;
        end
      end
      S_PUSHL: begin
        cmd_o.push_en  = status_i.push_left_ok;
        cmd_o.push_sel = PUSH_LEFT;
        state_d        = S_PUSHR;
      end
      S_PUSHR: begin
        cmd_o.push_en  = status_i.push_right_ok;
        cmd_o.push_sel = PUSH_RIGHT;
        state_d        = S_POP;
      end
      S_EMIT_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_K;
        state_d      = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_EMIT_HD;
      end
      S_EMIT_HD: begin
        if (out_ready_i) begin
          cmd_o.out_clear = 1'b1;
          if (status_i.last_k) begin
            cmd_o.run_clear = 1'b1;
            state_d         = S_LOAD;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      pivot_swap_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      pivot_swap_q <= pivot_swap_d;
    end
  end

endmodule

// File: rtl/core/quicksort_lomuto_engine.sv
// Top level of the quicksort engine: joins controller and datapath.
// Depends on qle_pkg, qle_ctrl and qle_dp.
//
// Usage: keys arrive on the input channel (valid/ready), one beat per key,
// taken one per cycle while the block is loading. Up to 64 keys are stored;
// later keys are dropped and the overflow flag is raised for the run. The
// beat with last_key set closes the set and starts an in-place quicksort
// (last element as pivot, explicit stack of ranges in a 64-entry memory).
// The sort starts by pushing the whole range and ends on finding the stack
// empty. Each range is popped, its pivot fetched, its keys compared and
// swapped (the pivot swap included), the scan closed and both subranges
// checked for pushing; all element accesses go through the single read
// and write port of the element store. A set of one key skips the sort.
// The sorted keys then leave on the output channel as one beat per key,
// each read from the element store into an output register, where the
// result beat sits until the receiver takes it. No new key is
// accepted from the last key until the final result beat is taken.
// Reset clears the count, tallies, stack pointer and flags; the stores
// need no clearing since only written entries are ever read.
`timescale 1ns / 1ps

module quicksort_lomuto_engine import qle_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [KEY_WIDTH-1:0] key_value_i,
  input  logic                 last_key_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [KEY_WIDTH-1:0] sorted_value_o,
  output logic [IDX_W-1:0]     position_o,
  output logic                 end_of_run_o,
  output logic [TALLY_W-1:0]   compare_count_o,
  output logic [TALLY_W-1:0]   swap_count_o,
  output logic                 overflow_flag_o
);

  qle_cmd_t    cmd;
  qle_status_t status;

  // Sequencer.
  qle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_key_i  (last_key_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic.
  qle_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .key_value_i     (key_value_i),
    .out_valid_o     (out_valid_o),
    .sorted_value_o  (sorted_value_o),
    .position_o      (position_o),
    .end_of_run_o    (end_of_run_o),
    .compare_count_o (compare_count_o),
    .swap_count_o    (swap_count_o),
    .overflow_flag_o (overflow_flag_o)
  );

endmodule
